/* src/tss_pkg.sv */
// shared types, constants and saturating helpers for the tridiagonal solver
// no dependencies; imported by every module of the block
package tss_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int ADDR_W    = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int DVD_W     = WORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int WIDE_W    = PROD_W + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_FX   = word_t'(64'(1) << FRAC_BITS);

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_ZERO_PIVOT = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } in_row_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last_result;
    logic [1:0]         status;
  } out_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_R0_DIVC, ST_R0_WAITC, ST_R0_DIVD, ST_R0_WAITD,
    ST_RD, ST_MUL_ACP, ST_DEN, ST_DIV_M, ST_WAIT_M, ST_MUL_CM,
    ST_WR_C, ST_SUB_D, ST_MUL_SM, ST_WR_D, ST_ROW_DONE,
    ST_BK_RD, ST_BK_MUL, ST_BK_SUB, ST_BK_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_A_CP, MUL_C_M, MUL_A_DP, MUL_T_M, MUL_CP_NX
  } mul_sel_e;

  typedef enum logic [1:0] {
    T_B_MINUS, T_D_MINUS, T_DP_MINUS, T_DP
  } t_sel_e;

  typedef enum logic [1:0] {
    DIV_C_B, DIV_D_B, DIV_ONE_T
  } div_sel_e;

  typedef struct packed {
    logic              load_row;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              t_en;
    t_sel_e            t_sel;
    logic              div_start;
    div_sel_e          div_sel;
    logic              m_en;
    logic              wr_super;
    logic              wr_rhs;
    logic              wr_from_div;
    logic [ADDR_W-1:0] wr_addr;
    logic              next_en;
    logic              out_load;
    logic [ADDR_W-1:0] out_row;
    logic              out_last;
    logic [1:0]        out_status;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_zero;
  } sts_t;

  function automatic word_t sat_word(input wide_t v);
    if (v > wide_t'(WORD_MAX)) begin
      return WORD_MAX;
    end else if (v < wide_t'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t x, input word_t y);
    return sat_word(wide_t'(x) - wide_t'(y));
  endfunction

endpackage

/* src/tss_div.sv */
// iterative restoring divider, one quotient bit per cycle, saturating result
// depends on tss_pkg
module tss_div import tss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t dvd_i,
  input  word_t dsr_i,
  output logic  done_o,
  output logic  zero_o,
  output word_t res_o
);

  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (WORD_BITS - 1);
  localparam logic [DVD_W-1:0] POS_LIM = NEG_LIM - DVD_W'(1);

  logic                 busy_q, fin_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]     sh_q;
  logic [WORD_BITS-1:0] rem_q, dsr_q;
  logic                 neg_q, xneg_q, zero_q;
  word_t                res_q;

  logic [WORD_BITS-1:0] mag_x, mag_y;
  logic [WORD_BITS:0]   remsh, diff;
  logic                 ge;
  word_t                res_d;

  always_comb begin
    mag_x = dvd_i[WORD_BITS-1] ? (~dvd_i + 1'b1) : dvd_i;
    mag_y = dsr_i[WORD_BITS-1] ? (~dsr_i + 1'b1) : dsr_i;
    remsh = {rem_q, sh_q[DVD_W-1]};
    diff  = remsh - {1'b0, dsr_q};
    ge    = remsh >= {1'b0, dsr_q};
    if (zero_q) begin
      res_d = xneg_q ? WORD_MIN : WORD_MAX;
    end else if (neg_q) begin
      res_d = (sh_q > NEG_LIM) ? WORD_MIN : word_t'(~sh_q[WORD_BITS-1:0] + 1'b1);
    end else begin
      res_d = (sh_q > POS_LIM) ? WORD_MAX : word_t'(sh_q[WORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q   <= DVD_W'(mag_x) << FRAC_BITS;
      dsr_q  <= mag_y;
      rem_q  <= '0;
      neg_q  <= dvd_i[WORD_BITS-1] ^ dsr_i[WORD_BITS-1];
      xneg_q <= dvd_i[WORD_BITS-1];
      zero_q <= (dsr_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? diff[WORD_BITS-1:0] : remsh[WORD_BITS-1:0];
      sh_q  <= {sh_q[DVD_W-2:0], ge};
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign zero_o = zero_q;
  assign res_o  = res_q;

endmodule

/* src/tss_dp.sv */
// solver datapath: row registers, coefficient stores, multiplier, divider
// depends on tss_pkg and tss_div
module tss_dp import tss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  input  in_row_t  in_data_i,
  output sts_t     sts_o,
  output out_res_t out_data_o
);

  word_t    super_mem [MAX_ROWS];
  word_t    rhs_mem   [MAX_ROWS];

  word_t    a_q, b_q, c_q, d_q;
  word_t    cp_q, dp_q, t_q, m_q, nx_q;
  prod_t    prod_q;
  out_res_t out_q;

  word_t    mul_x, mul_y, mul_res, t_d, wr_data;
  word_t    div_x, div_y, div_res;
  logic     div_done, div_zero;

  tss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (div_x),
    .dsr_i   (div_y),
    .done_o  (div_done),
    .zero_o  (div_zero),
    .res_o   (div_res)
  );

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_A_CP:  begin mul_x = a_q;  mul_y = cp_q; end
      MUL_C_M:   begin mul_x = c_q;  mul_y = m_q;  end
      MUL_A_DP:  begin mul_x = a_q;  mul_y = dp_q; end
      MUL_T_M:   begin mul_x = t_q;  mul_y = m_q;  end
      MUL_CP_NX: begin mul_x = cp_q; mul_y = nx_q; end
      default:   begin mul_x = a_q;  mul_y = cp_q; end
    endcase
    case (cmd_i.div_sel)
      DIV_C_B:   begin div_x = c_q;    div_y = b_q; end
      DIV_D_B:   begin div_x = d_q;    div_y = b_q; end
      DIV_ONE_T: begin div_x = ONE_FX; div_y = t_q; end
      default:   begin div_x = c_q;    div_y = b_q; end
    endcase
    mul_res = sat_word(wide_t'(prod_q >>> FRAC_BITS));
    case (cmd_i.t_sel)
      T_B_MINUS:  t_d = sat_sub(b_q, mul_res);
      T_D_MINUS:  t_d = sat_sub(d_q, mul_res);
      T_DP_MINUS: t_d = sat_sub(dp_q, mul_res);
      T_DP:       t_d = dp_q;
      default:    t_d = dp_q;
    endcase
    wr_data = cmd_i.wr_from_div ? div_res : mul_res;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      a_q <= in_data_i.sub_diag;
      b_q <= in_data_i.main_diag;
      c_q <= in_data_i.super_diag;
      d_q <= in_data_i.rhs_value;
    end
    if (cmd_i.rd_en) begin
      cp_q <= super_mem[cmd_i.rd_addr];
      dp_q <= rhs_mem[cmd_i.rd_addr];
    end
    if (cmd_i.wr_super) begin
      super_mem[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.wr_rhs) begin
      rhs_mem[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_t'(mul_x) * prod_t'(mul_y);
    end
    if (cmd_i.t_en) begin
      t_q <= t_d;
    end
    if (cmd_i.m_en) begin
      m_q <= div_res;
    end
    if (cmd_i.next_en) begin
      nx_q <= t_q;
    end
    if (cmd_i.out_load) begin
      out_q.solution    <= t_q;
      out_q.row_index   <= 6'(cmd_i.out_row);
      out_q.last_result <= cmd_i.out_last;
      out_q.status      <= cmd_i.out_status;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.div_zero = div_zero;
  assign out_data_o     = out_q;

endmodule

/* src/tss_ctrl.sv */
// solver controller: forward sweep per row, backward sweep, run state
// depends on tss_pkg
module tss_ctrl import tss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  rc_q, rc_d;
  logic [1:0]        err_q, err_d;
  logic              last_q, last_d, first_q, first_d, ov_q, ov_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rc_q    <= '0;
      err_q   <= STAT_OK;
      last_q  <= 1'b0;
      first_q <= 1'b0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      err_q   <= err_d;
      last_q  <= last_d;
      first_q <= first_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rc_d    = rc_q;
    err_d   = err_q;
    last_d  = last_q;
    first_d = first_q;
    idx_d   = idx_q;
    ov_d    = out_ready_i ? 1'b0 : ov_q;
    cmd_o   = '0;
    in_ready_o = (state_q == ST_IDLE);

    if (sts_i.div_done && sts_i.div_zero && err_q == STAT_OK) begin
      err_d = STAT_ZERO_PIVOT;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_row = 1'b1;
          last_d = in_last_i;
          if (rc_q == CNT_W'(MAX_ROWS)) begin
            err_d = STAT_OVERFLOW;
            if (in_last_i) begin
              idx_d   = ADDR_W'(rc_q - 1'b1);
              first_d = 1'b1;
              state_d = ST_BK_RD;
            end
          end else if (rc_q == '0) begin
            state_d = ST_R0_DIVC;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_R0_DIVC: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_C_B;
        state_d = ST_R0_WAITC;
      end
      ST_R0_WAITC: begin
        if (sts_i.div_done) begin
          cmd_o.wr_super    = 1'b1;
          cmd_o.wr_from_div = 1'b1;
          state_d = ST_R0_DIVD;
        end
      end
      ST_R0_DIVD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_D_B;
        state_d = ST_R0_WAITD;
      end
      ST_R0_WAITD: begin
        if (sts_i.div_done) begin
          cmd_o.wr_rhs      = 1'b1;
          cmd_o.wr_from_div = 1'b1;
          state_d = ST_ROW_DONE;
        end
      end
      ST_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = ADDR_W'(rc_q - 1'b1);
        state_d = ST_MUL_ACP;
      end
      ST_MUL_ACP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A_CP;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.t_en  = 1'b1;
        cmd_o.t_sel = T_B_MINUS;
        state_d = ST_DIV_M;
      end
      ST_DIV_M: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ONE_T;
        state_d = ST_WAIT_M;
      end
      ST_WAIT_M: begin
        if (sts_i.div_done) begin
          cmd_o.m_en = 1'b1;
          state_d = ST_MUL_CM;
        end
      end
      ST_MUL_CM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_C_M;
        state_d = ST_WR_C;
      end
      ST_WR_C: begin
        cmd_o.wr_super = 1'b1;
        cmd_o.wr_addr  = rc_q[ADDR_W-1:0];
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_A_DP;
        state_d = ST_SUB_D;
      end
      ST_SUB_D: begin
        cmd_o.t_en  = 1'b1;
        cmd_o.t_sel = T_D_MINUS;
        state_d = ST_MUL_SM;
      end
      ST_MUL_SM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_T_M;
        state_d = ST_WR_D;
      end
      ST_WR_D: begin
        cmd_o.wr_rhs  = 1'b1;
        cmd_o.wr_addr = rc_q[ADDR_W-1:0];
        state_d = ST_ROW_DONE;
      end
      ST_ROW_DONE: begin
        rc_d = rc_q + 1'b1;
        if (last_q) begin
          idx_d   = rc_q[ADDR_W-1:0];
          first_d = 1'b1;
          state_d = ST_BK_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BK_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q;
        state_d = first_q ? ST_BK_SUB : ST_BK_MUL;
      end
      ST_BK_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CP_NX;
        state_d = ST_BK_SUB;
      end
      ST_BK_SUB: begin
        cmd_o.t_en  = 1'b1;
        cmd_o.t_sel = first_q ? T_DP : T_DP_MINUS;
        state_d = ST_BK_OUT;
      end
      ST_BK_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_row    = idx_q;
          cmd_o.out_last   = (idx_q == '0);
          cmd_o.out_status = err_q;
          cmd_o.next_en    = 1'b1;
          ov_d    = 1'b1;
          first_d = 1'b0;
          if (idx_q == '0) begin
            rc_d    = '0;
            err_d   = STAT_OK;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_BK_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

/* src/tridiagonal_system_solver_unit.sv */
// top level of the tridiagonal solver: controller plus datapath
// depends on tss_pkg, tss_ctrl, tss_dp
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    in_data_i  (in_row_t, one matrix row)
//   out      out_valid_o / out_ready_i  out_data_o (out_res_t, one solution)
//
// row 0 runs two divides; each later row runs one divide plus four
// multiplies; the divider sets the pace
// back sweep: one solution element at a time, output register in between
// rows are taken only while the controller is idle; a stalled output holds
// the back sweep, an output still waiting does not block the next row
// reset clears control state only; coefficient stores need no clearing
module tridiagonal_system_solver_unit import tss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_row_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_row),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
